>>> rtl/sfab_pkg.sv
// ---------------------------------------------------------------------------
// sfab_pkg: shared types and constants
// Field widths, slot layout and word packing for the free-address batcher.
// ---------------------------------------------------------------------------
package sfab_pkg;

	localparam int ADDR_W    = 36;
	localparam int BYTES_W   = 16;
	localparam int OFFSET_W  = 30;
	localparam int OFF_LSB   = 5;
	localparam int WORD_W    = 64;
	localparam int SLOTS     = 8;
	localparam int SLOT_W    = 3;
	localparam int WORDS     = 4;
	localparam int FILL_W    = 4;
	localparam int OUT_BIN_W = 3;
	localparam int CAP_W     = 32;

	// count at which a bin holds a full batch
	localparam logic [FILL_W-1:0] FILL_FULL = 4'd8;
	localparam logic [FILL_W-1:0] FILL_ONE  = 4'd1;
	localparam logic [SLOT_W-1:0] SLOT_FIRST = 3'd0;

	typedef logic [ADDR_W-1:0]   addr_t;
	typedef logic [BYTES_W-1:0]  bytes_t;
	typedef logic [OFFSET_W-1:0] offset_t;
	typedef logic [WORD_W-1:0]   word_t;
	typedef logic [FILL_W-1:0]   fill_t;

	// even slot at bits 2..31, odd slot at bits 34..63
	function automatic word_t pack_pair(input offset_t even_off, input offset_t odd_off);
		pack_pair = {odd_off, 2'b00, even_off, 2'b00};
	endfunction

endpackage

>>> rtl/sfab_bin_select.sv
// ---------------------------------------------------------------------------
// sfab_bin_select: size to bin mapping
// Finds the smallest power-of-two bin that holds a slab size.
// ---------------------------------------------------------------------------
module sfab_bin_select #(
	parameter int BIN_COUNT     = 8,
	parameter int MIN_SIZE_LOG2 = 5,
	parameter int BIN_W         = 3
) (
	input  sfab_pkg::bytes_t   slab_bytes,
	output logic               hit,
	output logic [BIN_W-1:0]   bin
);
	import sfab_pkg::*;

	logic [BIN_COUNT-1:0] fits;

	// one compare per bin against its capacity
	for (genvar i = 0; i < BIN_COUNT; i++) begin : g_cap
		localparam logic [CAP_W-1:0] CAP = CAP_W'(1) << (i + MIN_SIZE_LOG2);
		assign fits[i] = {{(CAP_W-BYTES_W){1'b0}}, slab_bytes} <= CAP;
	end

	// priority pick, lowest fitting bin wins
	always_comb begin
		hit = |fits;
		bin = '0;
		for (int i = BIN_COUNT - 1; i >= 0; i--) begin
			if (fits[i]) begin
				bin = BIN_W'(i);
			end
		end
	end

endmodule

>>> rtl/sfab_bin_store.sv
// ---------------------------------------------------------------------------
// sfab_bin_store: per-bin slot storage
// Holds eight offsets and a fill count per bin; presents a full batch.
// ---------------------------------------------------------------------------
module sfab_bin_store #(
	parameter int BIN_COUNT = 8,
	parameter int BIN_W     = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               upd,
	input  logic [BIN_W-1:0]   bin,
	input  sfab_pkg::offset_t  offset,
	output logic               full,
	output sfab_pkg::word_t    words [sfab_pkg::WORDS]
);
	import sfab_pkg::*;

	offset_t             slot_q [BIN_COUNT][SLOTS];
	fill_t               fill_q [BIN_COUNT];
	fill_t               fill_cur;
	logic [SLOT_W-1:0]   slot_idx;

	// state of the selected bin
	assign fill_cur = fill_q[bin];
	assign full     = fill_cur >= FILL_FULL;
	assign slot_idx = full ? SLOT_FIRST : fill_cur[SLOT_W-1:0];

	// batch view of the selected bin
	always_comb begin
		for (int w = 0; w < WORDS; w++) begin
			words[w] = pack_pair(slot_q[bin][2*w], slot_q[bin][2*w+1]);
		end
	end

	// fill counts; a full bin restarts at one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < BIN_COUNT; b++) begin
				fill_q[b] <= '0;
			end
		end else if (upd) begin
			fill_q[bin] <= full ? FILL_ONE : fill_cur + FILL_ONE;
		end
	end

	// slot payload; only read once all eight slots are written
	always_ff @(posedge clk) begin
		if (upd) begin
			slot_q[bin][slot_idx] <= offset;
		end
	end

endmodule

>>> rtl/slab_free_address_batcher.sv
// ---------------------------------------------------------------------------
// slab_free_address_batcher: freed slab offset batching
// Packs freed slab offsets into eight-entry batches, one batch per size bin.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, slab_address, slab_bytes) takes one
//   freed slab per transfer. The offset is (slab_address - base) >> 5, kept
//   to 30 bits; the size picks the smallest power-of-two bin. Sizes above
//   the largest bin are dropped without effect.
//   Output channel (out_valid/out_ready) gives a full batch when a return
//   hits a bin already holding eight offsets; that return starts a new batch.
//   Config channel (cfg_valid/cfg_ready, cfg_data) writes the base address;
//   cfg_ready is always high. Write it only while the block is idle.
// Timing:
//   An accepted item is held in the input register; its batch, if any, is
//   captured in the result register when the item leaves the input
//   register, and shows on the output from there. One item per cycle is
//   sustained while no batch waits on the receiver; the input register and
//   the result register each hold one item.
//   If the receiver stalls, the result register holds its batch and the
//   input register fills; in_ready drops until out_ready returns.
//   Reset empties all bins and clears the base address to zero.
// ---------------------------------------------------------------------------
module slab_free_address_batcher #(
	parameter int BIN_COUNT     = 8,
	parameter int MIN_SIZE_LOG2 = 5
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  sfab_pkg::addr_t                  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  sfab_pkg::addr_t                  slab_address,
	input  sfab_pkg::bytes_t                 slab_bytes,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [sfab_pkg::OUT_BIN_W-1:0]   bin_index,
	output sfab_pkg::word_t                  batch_word0,
	output sfab_pkg::word_t                  batch_word1,
	output sfab_pkg::word_t                  batch_word2,
	output sfab_pkg::word_t                  batch_word3
);
	import sfab_pkg::*;

	localparam int BIN_W = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;

	addr_t                base_q;
	logic                 valid_s1;
	addr_t                addr_s1;
	bytes_t               bytes_s1;
	logic                 out_valid_q;
	logic [OUT_BIN_W-1:0] bin_q;
	word_t                word_q [WORDS];

	addr_t                diff;
	offset_t              offset;
	logic                 hit;
	logic [BIN_W-1:0]     bin;
	logic                 full;
	word_t                words [WORDS];
	logic                 advance;
	logic                 emit;
	logic [BIN_W+OUT_BIN_W-1:0] bin_ext;

	// base address register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_valid) begin
			base_q <= cfg_data;
		end
	end

	// stage handshake
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign emit     = advance && hit && full;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			addr_s1  <= slab_address;
			bytes_s1 <= slab_bytes;
		end
	end

	// offset: wrapped difference, bits 5..34
	assign diff   = addr_s1 - base_q;
	assign offset = diff[OFF_LSB +: OFFSET_W];

	sfab_bin_select #(
		.BIN_COUNT     (BIN_COUNT),
		.MIN_SIZE_LOG2 (MIN_SIZE_LOG2),
		.BIN_W         (BIN_W)
	) u_select (
		.slab_bytes (bytes_s1),
		.hit        (hit),
		.bin        (bin)
	);

	sfab_bin_store #(
		.BIN_COUNT (BIN_COUNT),
		.BIN_W     (BIN_W)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (advance && hit),
		.bin    (bin),
		.offset (offset),
		.full   (full),
		.words  (words)
	);

	// result register
	assign bin_ext = {{OUT_BIN_W{1'b0}}, bin};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			bin_q <= bin_ext[OUT_BIN_W-1:0];
			for (int w = 0; w < WORDS; w++) begin
				word_q[w] <= words[w];
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign bin_index   = bin_q;
	assign batch_word0 = word_q[0];
	assign batch_word1 = word_q[1];
	assign batch_word2 = word_q[2];
	assign batch_word3 = word_q[3];

endmodule
